// ===== design/particle_box_bounce_step_assert.svh =====
// assertion macros used by the checker file
`ifndef PARTICLE_BOX_BOUNCE_STEP_ASSERT_SVH
`define PARTICLE_BOX_BOUNCE_STEP_ASSERT_SVH

// condition holds in the same cycle
`define PBB_ASSERT_NOW(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// condition holds in the next cycle
`define PBB_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== design/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg
// shared constants, command and status types, fixed-point helpers
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_FORCE_X = 3'd0;
  localparam logic [2:0] REG_FORCE_Y = 3'd1;
  localparam logic [2:0] REG_FORCE_Z = 3'd2;
  localparam logic [2:0] REG_DRAG    = 3'd3;
  localparam logic [2:0] REG_MASS    = 3'd4;
  localparam logic [2:0] REG_TSTEP   = 3'd5;
  localparam logic [2:0] REG_LIMIT   = 3'd6;

  // wall faces
  localparam logic [2:0] FACE_XP = 3'd0;
  localparam logic [2:0] FACE_XN = 3'd1;
  localparam logic [2:0] FACE_YP = 3'd2;
  localparam logic [2:0] FACE_YN = 3'd3;
  localparam logic [2:0] FACE_ZP = 3'd4;
  localparam logic [2:0] FACE_ZN = 3'd5;

  // datapath operations
  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_START  = 5'd2;
  localparam logic [4:0] OP_VV     = 5'd3;
  localparam logic [4:0] OP_DR     = 5'd4;
  localparam logic [4:0] OP_DIVA   = 5'd5;
  localparam logic [4:0] OP_ACC    = 5'd6;
  localparam logic [4:0] OP_AH     = 5'd7;
  localparam logic [4:0] OP_WNV    = 5'd8;
  localparam logic [4:0] OP_VH     = 5'd9;
  localparam logic [4:0] OP_WNP    = 5'd10;
  localparam logic [4:0] OP_HCHK   = 5'd11;
  localparam logic [4:0] OP_DIVF   = 5'd12;
  localparam logic [4:0] OP_FRAC   = 5'd13;
  localparam logic [4:0] OP_SQ1    = 5'd14;
  localparam logic [4:0] OP_SQ2    = 5'd15;
  localparam logic [4:0] OP_SQS    = 5'd16;
  localparam logic [4:0] OP_LEN    = 5'd17;
  localparam logic [4:0] OP_D10    = 5'd18;
  localparam logic [4:0] OP_KEEP   = 5'd19;
  localparam logic [4:0] OP_MK     = 5'd20;
  localparam logic [4:0] OP_DK     = 5'd21;
  localparam logic [4:0] OP_WT     = 5'd22;
  localparam logic [4:0] OP_REFL   = 5'd23;
  localparam logic [4:0] OP_COMMIT = 5'd24;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic hit;
    logic fric;
  } stat_t;

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // saturated magnitude for a signed 32-bit result
  function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      sat_mag = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : m[31:0];
    end else begin
      sat_mag = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
  endfunction

  // apply a sign to a magnitude
  function automatic logic [31:0] to_signed(input logic [31:0] m, input logic neg);
    to_signed = neg ? (~m + 32'd1) : m;
  endfunction

  // saturating signed 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

// ===== design/pbb_div.sv =====
// ----------------------------------------------------------------------------
// pbb_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pbb_div
  import pbb_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = DW'(trial - {1'b0, den_r});
      quo_nxt = {quo_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== design/pbb_sqrt.sv =====
// ----------------------------------------------------------------------------
// pbb_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module pbb_sqrt
  import pbb_pkg::*;
#(
  parameter int XW = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic [XW/2-1:0] root,
  output logic            done
);

  localparam int RW = XW / 2;
  localparam int CW = $clog2(RW);
  localparam logic [CW-1:0] LAST = CW'(RW - 1);

  logic [RW+1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [XW-1:0] x_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [RW+3:0] r2, trial;

  // next two radicand bits against the trial root
  always_comb begin
    r2    = {rem_r, x_r[XW-1:XW-2]};
    trial = {2'b00, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      root_r <= '0;
      x_r    <= x;
    end else if (busy_r) begin
      x_r <= {x_r[XW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_r  <= (RW+2)'(r2 - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= r2[RW+1:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== design/pbb_datapath.sv =====
// ----------------------------------------------------------------------------
// pbb_datapath
// state, configuration, shared multiplier, divider and square root
// ----------------------------------------------------------------------------
module pbb_datapath
  import pbb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          ld_pos [3],
  input  logic [31:0]          ld_vel [3],
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [31:0]          res_pos [3],
  output logic [31:0]          res_vel [3],
  output logic                 res_hit,
  output logic [2:0]           res_face,
  output logic [FRAC_BITS:0]   res_time
);

  localparam int TW = FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int SLOW_I = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic [31:0] SLOW_Q = 32'(SLOW_I);
  // reciprocal of ten, exact for any 32-bit dividend after a 35-bit shift
  localparam logic [31:0] DIV10_M = 32'hCCCC_CCCD;

  // configuration
  logic [31:0]   force_r [3];
  logic [30:0]   drag_r, mass_r, lim_r;
  logic [TW-1:0] tstep_r;

  // particle state and step scratch
  logic [31:0]   pos_r [3];
  logic [31:0]   vel_r [3];
  logic [31:0]   acc_r [3];
  logic [31:0]   np_r  [3];
  logic [31:0]   nv_r  [3];
  logic [63:0]   prod_r, sq_r;
  logic          psign_r, psign_nxt, dsign_r;
  logic [TW-1:0] hmul_r, tout_r;
  logic          hit_r, cond_r, ge_r;
  logic [2:0]    face_r;
  logic [31:0]   len_r, keep_r;

  // result register
  logic [31:0]   opos_r [3];
  logic [31:0]   ovel_r [3];
  logic          ohit_r;
  logic [2:0]    oface_r;
  logic [TW-1:0] otime_r;

  logic [TW-1:0] h;
  logic [1:0]    ax, t1, t2, tsel, pos_a, nv_a;
  logic [31:0]   vel_rd, acc_rd, force_rd, pos_rd, np_ax, nv_rd;
  logic [63:0]   q_mag;
  logic [31:0]   qm_u, q_s;
  logic [33:0]   nsum, nneg;
  logic [32:0]   nmag;
  logic [32:0]   height, dsub, dneg, dmag;
  logic          cond, ge;
  logic          hit;
  logic [2:0]    face;
  logic [TW-1:0] frac;
  logic [2*TW-1:0] hcp;
  logic [31:0]   ma, mb, fr;
  logic [28:0]   q10;
  logic          do_mul, div_go, sq_go;
  logic [63:0]   div_num, div_q;
  logic [32:0]   div_den;
  logic          div_done, sq_done;
  logic [31:0]   root;
  logic [32:0]   lim33;
  logic [32:0]   np33 [3];
  logic [2:0]    gt, lt;

  // step clamped to one
  assign h = (tstep_r > ONE_Q) ? ONE_Q : tstep_r;

  // axis selection
  assign ax    = face_r[2:1];
  assign t1    = (ax == 2'd2) ? 2'd0 : ax + 2'd1;
  assign t2    = (ax == 2'd0) ? 2'd2 : ax - 2'd1;
  assign tsel  = cmd.idx[0] ? t2 : t1;
  assign pos_a = (cmd.op == OP_DIVF) ? ax : cmd.idx;

  always_comb begin
    case (cmd.op)
      OP_SQ1:        nv_a = t1;
      OP_SQ2:        nv_a = t2;
      OP_MK, OP_WT:  nv_a = tsel;
      default:       nv_a = ax;
    endcase
  end

  assign vel_rd   = vel_r[cmd.idx];
  assign acc_rd   = acc_r[cmd.idx];
  assign force_rd = force_r[cmd.idx];
  assign pos_rd   = pos_r[pos_a];
  assign np_ax    = np_r[ax];
  assign nv_rd    = nv_r[nv_a];

  // scaled, saturated product
  assign q_mag = prod_r >> FRAC_BITS;
  assign qm_u  = sat_mag(q_mag, psign_r);
  assign q_s   = to_signed(qm_u, psign_r);

  // force minus drag numerator
  assign nsum = {{2{force_rd[31]}}, force_rd} - {{2{q_s[31]}}, q_s};
  assign nneg = ~nsum + 34'd1;
  assign nmag = nsum[33] ? nneg[32:0] : nsum[32:0];

  // height to wall and travel on the hit axis
  assign height = {2'b00, lim_r} - {1'b0, abs32(pos_rd)};
  assign dsub   = {np_ax[31], np_ax} - {pos_rd[31], pos_rd};
  assign dneg   = ~dsub + 33'd1;
  assign dmag   = dsub[32] ? dneg : dsub;
  assign cond   = !height[32] && (height != '0) && (dmag != '0);
  assign ge     = {1'b0, height[31:0]} >= dmag;

  // wall test in face order
  assign lim33 = {2'b00, lim_r};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np33[i] = {np_r[i][31], np_r[i]};
      gt[i]   = $signed(np33[i]) > $signed(lim33);
      lt[i]   = $signed(np33[i]) < -$signed(lim33);
    end
    hit  = 1'b1;
    face = FACE_XP;
    if (gt[0])      face = FACE_XP;
    else if (lt[0]) face = FACE_XN;
    else if (gt[1]) face = FACE_YP;
    else if (lt[1]) face = FACE_YN;
    else if (gt[2]) face = FACE_ZP;
    else if (lt[2]) face = FACE_ZN;
    else begin
      hit  = 1'b0;
      face = FACE_XP;
    end
  end

  // hit fraction times step
  assign frac = !cond_r ? '0 : (ge_r ? ONE_Q : div_q[FRAC_BITS:0]);
  assign hcp  = {{TW{1'b0}}, frac} * {{TW{1'b0}}, h};

  // friction amount, a tenth of the normal speed, limited to the tangential speed
  assign q10 = prod_r[63:35];
  assign fr  = ({3'd0, q10} > len_r) ? len_r : {3'd0, q10};

  // operand selection for the shared units
  always_comb begin
    ma        = '0;
    mb        = '0;
    psign_nxt = psign_r;
    do_mul    = 1'b0;
    div_go    = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_go     = 1'b0;
    case (cmd.op)
      OP_VV: begin
        do_mul    = 1'b1;
        ma        = abs32(vel_rd);
        mb        = abs32(vel_rd);
        psign_nxt = vel_rd[31];
      end
      OP_DR: begin
        do_mul = 1'b1;
        ma     = {1'b0, drag_r};
        mb     = qm_u;
      end
      OP_DIVA: begin
        div_go  = 1'b1;
        div_num = {31'd0, nmag} << FRAC_BITS;
        div_den = (mass_r == '0) ? 33'd1 : {2'b00, mass_r};
      end
      OP_AH: begin
        do_mul    = 1'b1;
        ma        = abs32(acc_rd);
        mb        = {{(32-TW){1'b0}}, hmul_r};
        psign_nxt = acc_rd[31];
      end
      OP_VH: begin
        do_mul    = 1'b1;
        ma        = abs32(vel_rd);
        mb        = {{(32-TW){1'b0}}, hmul_r};
        psign_nxt = vel_rd[31];
      end
      OP_DIVF: begin
        div_go  = 1'b1;
        div_num = {32'd0, height[31:0]} << FRAC_BITS;
        div_den = dmag;
      end
      OP_SQ1, OP_SQ2: begin
        do_mul    = 1'b1;
        ma        = abs32(nv_rd);
        mb        = abs32(nv_rd);
        psign_nxt = 1'b0;
      end
      OP_SQS: begin
        sq_go = 1'b1;
      end
      OP_D10: begin
        do_mul    = 1'b1;
        ma        = abs32(nv_rd);
        mb        = DIV10_M;
        psign_nxt = 1'b0;
      end
      OP_MK: begin
        do_mul    = 1'b1;
        ma        = abs32(nv_rd);
        mb        = keep_r;
        psign_nxt = 1'b0;
      end
      OP_DK: begin
        div_go  = 1'b1;
        div_num = prod_r;
        div_den = {1'b0, len_r};
      end
      default: begin
      end
    endcase
  end

  // shared divider
  pbb_div #(.NW(64), .DW(33)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  // square root of the tangential speed squared
  pbb_sqrt #(.XW(64)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_go),
    .x     (sq_r + prod_r),
    .root  (root),
    .done  (sq_done)
  );

  // configuration and committed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r[0] <= 32'd0;
      force_r[1] <= 32'd0;
      force_r[2] <= 32'hFFFF_0000;
      drag_r     <= 31'd0;
      mass_r     <= 31'd65536;
      tstep_r    <= TW'(655);
      lim_r      <= 31'd294912;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FORCE_X: force_r[0] <= cfg_data;
          REG_FORCE_Y: force_r[1] <= cfg_data;
          REG_FORCE_Z: force_r[2] <= cfg_data;
          REG_DRAG:    drag_r     <= cfg_data[30:0];
          REG_MASS:    mass_r     <= cfg_data[30:0];
          REG_TSTEP:   tstep_r    <= cfg_data[TW-1:0];
          REG_LIMIT:   lim_r      <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= np_r[i];
          vel_r[i] <= nv_r[i];
        end
      end
    end
  end

  // step scratch and result register
  always_ff @(posedge clk) begin
    if (do_mul) begin
      prod_r  <= {32'd0, ma} * {32'd0, mb};
      psign_r <= psign_nxt;
    end
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          np_r[i] <= ld_pos[i];
          nv_r[i] <= ld_vel[i];
        end
        hit_r  <= 1'b0;
        face_r <= FACE_XP;
        tout_r <= '0;
      end
      OP_START: begin
        hmul_r <= h;
        tout_r <= h;
        hit_r  <= 1'b0;
        face_r <= FACE_XP;
      end
      OP_DIVA:  dsign_r <= nsum[33];
      OP_ACC:   acc_r[cmd.idx] <= to_signed(sat_mag(div_q, dsign_r), dsign_r);
      OP_WNV:   nv_r[cmd.idx] <= sat_add(vel_rd, q_s);
      OP_WNP:   np_r[cmd.idx] <= sat_add(pos_rd, q_s);
      OP_HCHK: begin
        hit_r  <= hit;
        face_r <= face;
      end
      OP_DIVF: begin
        cond_r <= cond;
        ge_r   <= ge;
      end
      OP_FRAC: begin
        hmul_r <= hcp[FRAC_BITS +: TW];
        tout_r <= hcp[FRAC_BITS +: TW];
      end
      OP_SQ2:   sq_r <= prod_r;
      OP_LEN:   len_r <= root;
      OP_KEEP:  keep_r <= len_r - fr;
      OP_WT:    nv_r[nv_a] <= to_signed(div_q[31:0], nv_rd[31]);
      OP_REFL:  nv_r[nv_a] <= to_signed(abs32(nv_rd) >> 1, ~nv_rd[31]);
      OP_COMMIT: begin
        for (int i = 0; i < 3; i++) begin
          opos_r[i] <= np_r[i];
          ovel_r[i] <= nv_r[i];
        end
        ohit_r  <= hit_r;
        oface_r <= face_r;
        otime_r <= tout_r;
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sq_done;
  assign stat.hit       = hit;
  assign stat.fric      = root > SLOW_Q;

  assign res_pos  = opos_r;
  assign res_vel  = ovel_r;
  assign res_hit  = ohit_r;
  assign res_face = oface_r;
  assign res_time = otime_r;

endmodule

// ===== design/pbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbb_ctrl
// step sequencer and channel handshakes
// ----------------------------------------------------------------------------
module pbb_ctrl
  import pbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_mode,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_VV     = 5'd1;
  localparam logic [4:0] ST_DR     = 5'd2;
  localparam logic [4:0] ST_DIVA   = 5'd3;
  localparam logic [4:0] ST_WAITA  = 5'd4;
  localparam logic [4:0] ST_ACC    = 5'd5;
  localparam logic [4:0] ST_AH     = 5'd6;
  localparam logic [4:0] ST_WNV    = 5'd7;
  localparam logic [4:0] ST_VH     = 5'd8;
  localparam logic [4:0] ST_WNP    = 5'd9;
  localparam logic [4:0] ST_HCHK   = 5'd10;
  localparam logic [4:0] ST_DIVF   = 5'd11;
  localparam logic [4:0] ST_WAITF  = 5'd12;
  localparam logic [4:0] ST_FRAC   = 5'd13;
  localparam logic [4:0] ST_SQ1    = 5'd14;
  localparam logic [4:0] ST_SQ2    = 5'd15;
  localparam logic [4:0] ST_SQS    = 5'd16;
  localparam logic [4:0] ST_WAITS  = 5'd17;
  localparam logic [4:0] ST_LEN    = 5'd18;
  localparam logic [4:0] ST_D10    = 5'd19;
  localparam logic [4:0] ST_KEEP   = 5'd21;
  localparam logic [4:0] ST_MK     = 5'd22;
  localparam logic [4:0] ST_DK     = 5'd23;
  localparam logic [4:0] ST_WAITK  = 5'd24;
  localparam logic [4:0] ST_WT     = 5'd25;
  localparam logic [4:0] ST_REFL   = 5'd26;
  localparam logic [4:0] ST_DONE   = 5'd27;

  logic [4:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       hitph_r, hitph_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [4:0] op;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hitph_nxt     = hitph_r;
    out_valid_nxt = out_valid_r && out_stall;
    op            = OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            op        = OP_LOAD;
            state_nxt = ST_DONE;
          end else begin
            op        = OP_START;
            idx_nxt   = 2'd0;
            hitph_nxt = 1'b0;
            state_nxt = ST_VV;
          end
        end
      end
      ST_VV: begin
        op        = OP_VV;
        state_nxt = ST_DR;
      end
      ST_DR: begin
        op        = OP_DR;
        state_nxt = ST_DIVA;
      end
      ST_DIVA: begin
        op        = OP_DIVA;
        state_nxt = ST_WAITA;
      end
      ST_WAITA: begin
        if (stat.div_done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        op = OP_ACC;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_AH;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_VV;
        end
      end
      ST_AH: begin
        op        = OP_AH;
        state_nxt = ST_WNV;
      end
      ST_WNV: begin
        op        = OP_WNV;
        state_nxt = ST_VH;
      end
      ST_VH: begin
        op        = OP_VH;
        state_nxt = ST_WNP;
      end
      ST_WNP: begin
        op = OP_WNP;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = hitph_r ? ST_SQ1 : ST_HCHK;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_AH;
        end
      end
      ST_HCHK: begin
        op        = OP_HCHK;
        state_nxt = stat.hit ? ST_DIVF : ST_DONE;
      end
      ST_DIVF: begin
        op        = OP_DIVF;
        state_nxt = ST_WAITF;
      end
      ST_WAITF: begin
        if (stat.div_done) state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        op        = OP_FRAC;
        hitph_nxt = 1'b1;
        idx_nxt   = 2'd0;
        state_nxt = ST_AH;
      end
      ST_SQ1: begin
        op        = OP_SQ1;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        op        = OP_SQ2;
        state_nxt = ST_SQS;
      end
      ST_SQS: begin
        op        = OP_SQS;
        state_nxt = ST_WAITS;
      end
      ST_WAITS: begin
        if (stat.sqrt_done) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        op        = OP_LEN;
        state_nxt = stat.fric ? ST_D10 : ST_REFL;
      end
      ST_D10: begin
        op        = OP_D10;
        state_nxt = ST_KEEP;
      end
      ST_KEEP: begin
        op        = OP_KEEP;
        idx_nxt   = 2'd0;
        state_nxt = ST_MK;
      end
      ST_MK: begin
        op        = OP_MK;
        state_nxt = ST_DK;
      end
      ST_DK: begin
        op        = OP_DK;
        state_nxt = ST_WAITK;
      end
      ST_WAITK: begin
        if (stat.div_done) state_nxt = ST_WT;
      end
      ST_WT: begin
        op = OP_WT;
        if (idx_r == 2'd1) begin
          state_nxt = ST_REFL;
        end else begin
          idx_nxt   = 2'd1;
          state_nxt = ST_MK;
        end
      end
      ST_REFL: begin
        op        = OP_REFL;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          op            = OP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      hitph_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hitph_r     <= hitph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.op    = op;
  assign cmd.idx   = idx_r;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/particle_box_bounce_step.sv =====
// A load result is offered once the DONE state commits it to the result register. A step result
// takes longer with a wall hit than without one, set mostly by the shift-subtract divider
// (three acceleration quotients, hit fraction, two friction scalings) and the square root.
// One item is worked at a time; the next beat is taken the cycle after the result register loads,
// and a stalled result holds the next item in the DONE state until the result slot frees.
// Synchronous active-low reset loads the register defaults and zeros position and velocity.
// ----------------------------------------------------------------------------
// particle_box_bounce_step
// ball in a box, one euler step with wall bounce per beat, Q16.16 fixed point
// ----------------------------------------------------------------------------
module particle_box_bounce_step
  import pbb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_load_pos_x,
  input  logic signed [31:0] in_load_pos_y,
  input  logic signed [31:0] in_load_pos_z,
  input  logic signed [31:0] in_load_vel_x,
  input  logic signed [31:0] in_load_vel_y,
  input  logic signed [31:0] in_load_vel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic               out_collided,
  output logic [2:0]         out_wall_face,
  output logic [FRAC_BITS:0] out_step_time
);

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] ld_pos [3];
  logic [31:0] ld_vel [3];
  logic [31:0] res_pos [3];
  logic [31:0] res_vel [3];

  // load fields as axis arrays
  assign ld_pos[0] = in_load_pos_x;
  assign ld_pos[1] = in_load_pos_y;
  assign ld_pos[2] = in_load_pos_z;
  assign ld_vel[0] = in_load_vel_x;
  assign ld_vel[1] = in_load_vel_y;
  assign ld_vel[2] = in_load_vel_z;

  pbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbb_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ld_pos    (ld_pos),
    .ld_vel    (ld_vel),
    .cmd       (cmd),
    .stat      (stat),
    .res_pos   (res_pos),
    .res_vel   (res_vel),
    .res_hit   (out_collided),
    .res_face  (out_wall_face),
    .res_time  (out_step_time)
  );

  // result beat fields
  assign out_pos_x = res_pos[0];
  assign out_pos_y = res_pos[1];
  assign out_pos_z = res_pos[2];
  assign out_vel_x = res_vel[0];
  assign out_vel_y = res_vel[1];
  assign out_vel_z = res_vel[2];

endmodule

// ===== design/pbb_checker.sv =====
// ----------------------------------------------------------------------------
// pbb_checker
// port-level checks on the top level, attached by bind
// ----------------------------------------------------------------------------
`include "particle_box_bounce_step_assert.svh"

module pbb_checker
  import pbb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_collided,
  input logic [2:0] out_wall_face
);

  // a stalled result beat stays offered
  `PBB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

  // one item at a time: busy right after an accepted beat
  `PBB_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")

  // no hit reports the first face code
  `PBB_ASSERT_NOW(a_face_no_hit, out_valid && !out_collided, out_wall_face == FACE_XP, "stray face")

  // hit face is one of the six walls
  `PBB_ASSERT_NOW(a_face_range, out_valid && out_collided, out_wall_face <= FACE_ZN, "bad face")

endmodule

bind particle_box_bounce_step pbb_checker u_pbb_checker (.*);
